[rtl/core/dctqz_pkg.sv]
// Package for the 8x8 DCT, quantize and zigzag block: payload types, tables, helpers.
package dctqz_pkg;

  localparam int DEF_FRAC_BITS = 2;
  localparam int BASIS_BITS    = 14;

  localparam logic [1:0] CFG_QUALITY = 2'd0;
  localparam logic [1:0] CFG_OFFSET  = 2'd1;

  localparam logic [6:0] QUALITY_RESET = 7'd50;
  localparam logic [7:0] OFFSET_RESET  = 8'd64;

  typedef struct packed {
    logic signed [10:0] sample_q2;
    logic               kind;
  } sample_t;

  typedef struct packed {
    logic [7:0] coef_byte;
    logic       last;
  } coef_t;

  localparam logic [7:0] LUMA [64] = '{
    8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
    8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
    8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
    8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
    8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
    8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
    8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
    8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99};

  localparam logic [7:0] CHROMA [64] = '{
    8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99};

  localparam logic [5:0] SCAN [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

  // Scaled cosine basis entry B[k][n], 14 fraction bits.
  function automatic logic signed [14:0] basis(input logic [2:0] k, input logic [2:0] n);
    logic [4:0]         m;
    logic               neg;
    logic signed [14:0] mag;
    m   = 5'({2'b00, k} * {1'b0, n, 1'b1});
    neg = 1'b0;
    if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
    if (m > 5'd8) begin
      m   = 5'(5'd16 - m);
      neg = 1'b1;
    end
    case (m)
      5'd0:    mag = 15'sd8192;
      5'd1:    mag = 15'sd8035;
      5'd2:    mag = 15'sd7568;
      5'd3:    mag = 15'sd6811;
      5'd4:    mag = 15'sd5793;
      5'd5:    mag = 15'sd4551;
      5'd6:    mag = 15'sd3135;
      5'd7:    mag = 15'sd1598;
      default: mag = 15'sd0;
    endcase
    if (k == 3'd0) return 15'sd5793;
    return neg ? -mag : mag;
  endfunction

endpackage

[rtl/core/block_dct_quantize_zigzag_core.sv]
// Top level: 8x8 forward DCT on one shared multiplier, quantizer and zigzag scan.
//
// Feed 64 samples of one 8x8 block in raster order; the kind bit of the first
// sample picks the luma table (scaled by quality_percent) or the fixed chroma
// table. Samples are taken one per cycle while loading. After the 64th sample the
// block raises sample_stall and runs a column pass and a row pass of 512
// multiply-accumulates each through one pipelined multiplier, then quantizes the
// 64 coefficients one at a time (q lookup, offset bias, rounding, then an 8-step
// restoring divide, which is skipped when the result clamps at 0 or 255), then
// emits the 64 bytes in zigzag order, holding each byte until it is taken, and
// flags the last. No sample of the next block is taken until the last byte is
// taken. Write configuration only while the block waits for the first sample
// of a block; cfg_ready is always high.
module block_dct_quantize_zigzag_core #(
  parameter int FRAC_BITS = dctqz_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  dctqz_pkg::sample_t sample,
  output logic               coef_valid,
  input  logic               coef_stall,
  output dctqz_pkg::coef_t   coef,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import dctqz_pkg::*;

  // Total shift of the exact 2D DCT result.
  localparam int S  = 2 * BASIS_BITS + FRAC_BITS;
  localparam int TW = S + 20;

  typedef enum logic [3:0] {
    S_LOAD, S_COL, S_ROW, S_QA, S_QB, S_QC, S_QD, S_QE, S_QF, S_QDIV, S_QW,
    S_ERD, S_ELD, S_EWAIT
  } state_t;

  state_t state;

  logic [6:0] quality_percent;
  logic [7:0] quant_offset;
  logic [5:0] load_cnt;
  logic       block_kind;

  // Memories
  logic        [10:0] sample_mem [64];
  logic signed [27:0] tmp_mem    [64];
  logic signed [43:0] d_mem      [64];
  logic        [7:0]  coef_mem   [64];

  logic        [10:0] sample_rd;
  logic signed [27:0] tmp_rd;
  logic signed [43:0] d_rd;
  logic        [7:0]  coef_rd;

  // MAC pipeline
  logic [8:0]         issue_cnt;
  logic               issue_done;
  logic               s1_valid, s1_first, s1_last;
  logic [5:0]         s1_dst;
  logic signed [14:0] s1_b;
  logic               s2_valid, s2_first, s2_last;
  logic [5:0]         s2_dst;
  logic signed [42:0] prod;
  logic signed [43:0] acc;
  logic signed [43:0] acc_sum;
  logic signed [27:0] mul_a;
  logic [5:0]         rd_addr_s;
  logic [5:0]         rd_addr_t;
  logic signed [14:0] issue_b;

  // Quantizer
  logic [5:0]           qi;
  logic [13:0]          qx;
  logic [26:0]          qprod;
  logic [7:0]           q;
  logic [7:0]           q_pick;
  logic [16:0]          mq;
  logic signed [TW-1:0] t_w;
  logic signed [17:0]   a;
  logic                 pos;
  logic [16:0]          rem;
  logic [16:0]          q_shift;
  logic [7:0]           quo;
  logic [2:0]           bitcnt;
  logic [5:0]           k;

  logic load_take;
  logic pipe_empty;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_LOAD);
  assign load_take    = sample_valid && (state == S_LOAD);
  assign pipe_empty   = issue_done && !s1_valid && !s2_valid;

  // Column pass reads s[r][c] with basis B[u][r]; row pass reads tmp[u][c] with B[v][c].
  assign rd_addr_s = {issue_cnt[2:0], issue_cnt[5:3]};
  assign rd_addr_t = {issue_cnt[8:6], issue_cnt[2:0]};
  assign issue_b   = (state == S_COL) ? basis(issue_cnt[8:6], issue_cnt[2:0])
                                      : basis(issue_cnt[5:3], issue_cnt[2:0]);

  assign mul_a   = (state == S_COL) ? {{17{sample_rd[10]}}, sample_rd} : tmp_rd;
  assign acc_sum = s2_first ? 44'(prod) : acc + 44'(prod);

  assign q_pick  = block_kind ? CHROMA[qi] : qprod[26:19];
  assign q_shift = 17'({9'b0, q} << bitcnt);

  // 2d + (2*offset+1)*q*2^S; its floor over 2^(S+1), divided by q, is the rounded quotient.
  assign t_w = {{(TW-45){d_rd[43]}}, d_rd, 1'b0} + ({{(TW-17){1'b0}}, mq} << S);

  // Memories and payload datapath: no reset.
  always_ff @(posedge clk) begin
    if (load_take) sample_mem[load_cnt] <= sample.sample_q2;
    sample_rd <= sample_mem[rd_addr_s];
    tmp_rd    <= tmp_mem[rd_addr_t];
    if (state == S_QA) d_rd <= d_mem[qi];
    coef_rd <= coef_mem[SCAN[k]];

    s1_b   <= issue_b;
    s1_dst <= issue_cnt[8:3];
    prod   <= mul_a * s1_b;
    s2_dst <= s1_dst;
    if (s2_valid) begin
      acc <= acc_sum;
      if (s2_last && state == S_COL) tmp_mem[s2_dst] <= acc_sum[27:0];
      if (s2_last && state == S_ROW) d_mem[s2_dst] <= acc_sum;
    end

    case (state)
      S_QA: qx <= 14'({6'b0, LUMA[qi]} * {7'b0, quality_percent} + 14'd99);
      S_QB: qprod <= 27'({13'b0, qx} * 27'd5243);
      S_QC: q <= (q_pick == 8'd0) ? 8'd1 : q_pick;
      S_QD: mq <= 17'({quant_offset, 1'b1} * {1'b0, q});
      S_QE: begin
        a   <= t_w[S+18:S+1];
        pos <= !t_w[TW-1] && (t_w != '0);
      end
      S_QF: begin
        rem <= a[16:0];
        quo <= (pos && a[16:0] >= {1'b0, q, 8'b0}) ? 8'hFF : 8'h00;
      end
      S_QDIV: begin
        if (rem >= q_shift) begin
          rem         <= rem - q_shift;
          quo[bitcnt] <= 1'b1;
        end
      end
      S_QW: coef_mem[qi] <= quo;
      default: ;
    endcase
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      quality_percent <= QUALITY_RESET;
      quant_offset    <= OFFSET_RESET;
      load_cnt        <= '0;
      block_kind      <= 1'b0;
      issue_cnt       <= '0;
      issue_done      <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      qi              <= '0;
      bitcnt          <= '0;
      k               <= '0;
      coef_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_QUALITY: quality_percent <= cfg_data[6:0];
          CFG_OFFSET:  quant_offset    <= cfg_data;
          default: ;
        endcase
      end

      // Advance the MAC pipeline.
      s1_valid <= 1'b0;
      s2_valid <= s1_valid;
      s2_first <= s1_first;
      s2_last  <= s1_last;

      case (state)
        S_LOAD: begin
          if (load_take) begin
            if (load_cnt == 6'd0) block_kind <= sample.kind;
            load_cnt <= load_cnt + 6'd1;
            if (load_cnt == 6'd63) state <= S_COL;
          end
        end
        S_COL, S_ROW: begin
          if (!issue_done) begin
            s1_valid  <= 1'b1;
            s1_first  <= (issue_cnt[2:0] == 3'd0);
            s1_last   <= (issue_cnt[2:0] == 3'd7);
            issue_cnt <= issue_cnt + 9'd1;
            if (issue_cnt == 9'd511) issue_done <= 1'b1;
          end else if (pipe_empty) begin
            issue_done <= 1'b0;
            state      <= (state == S_COL) ? S_ROW : S_QA;
          end
        end
        S_QA: state <= S_QB;
        S_QB: state <= S_QC;
        S_QC: state <= S_QD;
        S_QD: state <= S_QE;
        S_QE: state <= S_QF;
        S_QF: begin
          bitcnt <= 3'd7;
          // Skip the divide when the result clamps at either end.
          if (!pos || a[16:0] >= {1'b0, q, 8'b0}) state <= S_QW;
          else                                     state <= S_QDIV;
        end
        S_QDIV: begin
          bitcnt <= bitcnt - 3'd1;
          if (bitcnt == 3'd0) state <= S_QW;
        end
        S_QW: begin
          qi <= qi + 6'd1;
          if (qi == 6'd63) state <= S_ERD;
          else             state <= S_QA;
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          coef.coef_byte <= coef_rd;
          coef.last      <= (k == 6'd63);
          coef_valid     <= 1'b1;
          state          <= S_EWAIT;
        end
        S_EWAIT: begin
          if (!coef_stall) begin
            coef_valid <= 1'b0;
            k          <= k + 6'd1;
            state      <= (k == 6'd63) ? S_LOAD : S_ERD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    coef_valid |-> state == S_EWAIT)
    else $error("coef_valid outside the emit wait");

  a_last_ends_block: assert property (@(posedge clk) disable iff (rst)
    coef_valid && !coef_stall && coef.last |=> state == S_LOAD && load_cnt == 6'd0)
    else $error("block did not return to loading after the last byte");

  a_row_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_ROW) |-> !s1_valid && !s2_valid)
    else $error("row pass started before column pass drained");

  a_q_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_QD |-> q != 8'd0)
    else $error("zero quantizer");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_QDIV |-> rem < {1'b0, q, 8'b0})
    else $error("divider remainder out of range");

endmodule

[tb/dctqz_checker.sv]
// Checker for the DCT quantize zigzag core: watches the channels, predicts and compares.
module dctqz_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  dctqz_pkg::sample_t sample,
  input  logic               coef_valid,
  input  logic               coef_stall,
  input  dctqz_pkg::coef_t   coef,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import dctqz_pkg::*;

  logic signed [10:0] pixels [64];
  logic [5:0]         fill;
  logic               chroma;
  logic [6:0]         quality;
  logic [7:0]         offset;

  // Expected bytes in a ring; head is the next to compare, tail the next free slot.
  coef_t              exp_ring [128];
  int                 exp_head = 0;
  int                 exp_tail = 0;

  assign pending = exp_tail - exp_head;

  function automatic longint cosine(int k, int n);
    int m;
    longint sgn;
    longint mags [9] = '{8192, 8035, 7568, 6811, 5793, 4551, 3135, 1598, 0};
    sgn = 1;
    if (k == 0) return 5793;
    m = (k * (2 * n + 1)) & 31;
    if (m > 16) m = 32 - m;
    if (m > 8) begin
      m = 16 - m;
      sgn = -1;
    end
    return sgn * mags[m];
  endfunction

  // Transform, quantize and queue the 64 bytes of the finished block.
  task automatic quantize_block();
    longint colsum [8][8];
    logic [7:0] bytes [64];
    longint d, den, t, q, res;
    coef_t c;
    for (int u = 0; u < 8; u++)
      for (int cc = 0; cc < 8; cc++) begin
        colsum[u][cc] = 0;
        for (int r = 0; r < 8; r++)
          colsum[u][cc] += cosine(u, r) * longint'(pixels[r * 8 + cc]);
      end
    for (int u = 0; u < 8; u++)
      for (int v = 0; v < 8; v++) begin
        d = 0;
        for (int cc = 0; cc < 8; cc++) d += colsum[u][cc] * cosine(v, cc);
        if (chroma) q = CHROMA[u * 8 + v];
        else q = (longint'(LUMA[u * 8 + v]) * quality + 99) / 100;
        if (q == 0) q = 1;
        den = q << (2 * BASIS_BITS + DEF_FRAC_BITS);
        t = 2 * (d + longint'(offset) * den) + den;
        if (t <= 0) res = 0;
        else begin
          res = t / (2 * den);
          if (res > 255) res = 255;
        end
        bytes[u * 8 + v] = res[7:0];
      end
    for (int k = 0; k < 64; k++) begin
      c.coef_byte = bytes[SCAN[k]];
      c.last = (k == 63);
      exp_ring[7'(exp_tail)] = c;
      exp_tail++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      chroma = 1'b0;
      quality = QUALITY_RESET;
      offset = OFFSET_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_QUALITY) quality = cfg_data[6:0];
        else if (cfg_index == CFG_OFFSET) offset = cfg_data;
      end
      if (sample_valid && !sample_stall) begin
        if (fill == 0) chroma = sample.kind;
        pixels[fill] = sample.sample_q2;
        if (fill == 63) quantize_block();
        fill <= fill + 6'd1;
      end
      if (coef_valid && !coef_stall) begin
        if (exp_tail == exp_head) begin
          if (fail_count < 10) $display("unexpected coefficient %0h", coef);
          fail_count <= fail_count + 1;
        end else begin
          if (coef !== exp_ring[7'(exp_head)]) begin
            if (fail_count < 10)
              $display("coef mismatch: expected byte %0d last %0b, got byte %0d last %0b",
                       exp_ring[7'(exp_head)].coef_byte, exp_ring[7'(exp_head)].last,
                       coef.coef_byte, coef.last);
            fail_count <= fail_count + 1;
          end
          exp_head++;
        end
      end
    end
  end
endmodule

[tb/block_dct_quantize_zigzag_core_tb.sv]
// Testbench top: stimulus, idling and verdict for the DCT quantize zigzag core.
module block_dct_quantize_zigzag_core_tb;
  import dctqz_pkg::*;

  logic       clk;
  logic       rst;
  logic       sample_valid;
  logic       sample_stall;
  sample_t    sample;
  logic       coef_valid;
  logic       coef_stall;
  coef_t      coef;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         pending;
  int         cycles;

  // Allow the blocks plus stalls several times over.
  localparam int CYCLE_LIMIT = 100_000;

  block_dct_quantize_zigzag_core uut (.*);

  dctqz_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("block_dct_quantize_zigzag_core regression: fail");
        $finish;
      end
    end
  end

  // Stall the coefficient side on its own pattern: stretches that are quiet, heavily
  // stalled or lightly stalled, picked at random.
  initial begin
    int mode;
    int span;
    coef_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: coef_stall <= 1'b0;
          1: coef_stall <= ($urandom_range(0, 3) == 0);
          default: coef_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  int burst_left;

  // Offer one request and hold it until it is taken; gaps come between bursts.
  // Valid stays high inside a burst and drops only for a gap or at the end of a block.
  task automatic send_sample(logic signed [10:0] value, logic plane);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_valid <= 1'b1;
    sample.sample_q2 <= value;
    sample.kind <= plane;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic write_reg(logic [1:0] index, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all expected bytes, then give the block time to settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Send one block; pattern selects the content, kind only on the first sample
  // counts but later samples carry random kinds.
  task automatic send_block(int pattern, logic plane);
    logic signed [10:0] v;
    for (int i = 0; i < 64; i++) begin
      case (pattern)
        0: v = 11'sh3FF;
        1: v = -11'sd1024;
        2: v = ((i / 8 + i % 8) % 2) ? 11'sh3FF : -11'sd1024;
        3: v = 11'sd0;
        default: v = 11'($urandom);
      endcase
      send_sample(v, (i == 0) ? plane : 1'($urandom));
    end
    // Drop valid after the last request of the block.
    sample_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_QUALITY;
    cfg_data = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of content, both planes, reset settings.
    send_block(0, 1'b0);
    send_block(1, 1'b1);
    drain();
    // Quality one (most luma quantizer entries round up to one) with zero offset.
    write_reg(CFG_QUALITY, 8'd1);
    write_reg(CFG_OFFSET, 8'd0);
    send_block(2, 1'b0);
    drain();

    // Quality above 100 with the largest offset, then random settings and content.
    for (int p = 0; p < 2; p++) begin
      write_reg(CFG_QUALITY, (p == 0) ? 8'd127 : 8'($urandom_range(0, 127)));
      write_reg(CFG_OFFSET, (p == 0) ? 8'd255 : 8'($urandom));
      send_block((p == 0) ? 2 : int'($urandom_range(4, 9)), 1'($urandom));
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("block_dct_quantize_zigzag_core regression: pass");
    end else begin
      $display("block_dct_quantize_zigzag_core regression: fail");
    end
    $finish;
  end
endmodule
